[rtl/pur_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pur_pkg;

  localparam int COORD_W = 32;
  localparam int AXIS_N  = 3;
  localparam int SPACE_W = 31;
  localparam int PAD_W   = 3;

  // configuration register indexes
  localparam logic [1:0] REG_SPACING = 2'd0;
  localparam logic [1:0] REG_PAD     = 2'd1;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
    logic                      path_end;
  } way_item_t;

  typedef struct packed {
    logic [SPACE_W-1:0] spacing;
    logic [PAD_W-1:0]   pad;
  } cfg_t;

endpackage
`default_nettype wire

[rtl/polyline_uniform_resampler_top.sv]
// Polyline uniform resampler.
// Input stream s_*: one 3-D waypoint per transfer, s_tlast marks the final
// waypoint of a path. Output stream m_*: the resampled points, m_tlast on the
// last point caused by a waypoint, m_tuser set when the segment count was
// saturated at MAX_SEG_POINTS. Config channel cfg_*: index 0 sample spacing
// (unsigned Q15.16), index 1 pad count; write only while the block is idle.
// Waypoints go into a small queue; the back end takes one at a time.
// Per segment: squared length, bit-serial square root, count search, then
// serial division for the three interpolation steps (one per axis), then
// one output point per cycle while m_tready does not stall the output.
// The first waypoint of a path gives no output.
// If m_tready is low the back end holds in place; the queue keeps taking
// waypoints until it is full.
// Reset (rst, synchronous) empties the queue, drops any held waypoint and
// restores spacing 1.0 and pad count 5.
`timescale 1ns / 1ps
`default_nettype none
module polyline_uniform_resampler_top import pur_pkg::*; #(
  parameter int MAX_SEG_POINTS = 48,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [95:0]   s_tdata,  // way_x, way_y, way_z
  input  wire logic          s_tlast,  // path_end
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [95:0]        m_tdata,  // pos_x, pos_y, pos_z
  output logic               m_tlast,  // run_last
  output logic               m_tuser,  // count_clipped
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_data
);

  cfg_t cfg;
  way_item_t in_item;
  way_item_t q_item;
  logic q_valid;
  logic q_pop;
  logic signed [COORD_W-1:0] ox;
  logic signed [COORD_W-1:0] oy;
  logic signed [COORD_W-1:0] oz;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spacing <= SPACE_W'(65536);
      cfg.pad     <= PAD_W'(5);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SPACING: cfg.spacing <= cfg_data[SPACE_W-1:0];
        REG_PAD:     cfg.pad <= cfg_data[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_item.x = s_tdata[31:0];
  assign in_item.y = s_tdata[63:32];
  assign in_item.z = s_tdata[95:64];
  assign in_item.path_end = s_tlast;

  pur_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  pur_engine #(.MAX_SEG_POINTS(MAX_SEG_POINTS)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_x     (ox),
    .out_y     (oy),
    .out_z     (oz),
    .out_last  (m_tlast),
    .out_clip  (m_tuser)
  );

  assign m_tdata = {oz, oy, ox};

endmodule
`default_nettype wire

[rtl/pur_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module pur_front import pur_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire way_item_t in_item,
  output logic           q_valid,
  input  wire logic      q_pop,
  output way_item_t      q_item
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(QUEUE_DEPTH);

  way_item_t slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CNTW-1:0] count;
  logic push;
  logic pop;

  assign in_ready = (count != FULL_CNT);
  assign q_valid  = (count != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/pur_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
module pur_engine import pur_pkg::*; #(
  parameter int MAX_SEG_POINTS = 48
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cfg_t                cfg,
  input  wire logic                q_valid,
  output logic                     q_pop,
  input  wire way_item_t           q_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic signed [COORD_W-1:0] out_z,
  output logic                     out_last,
  output logic                     out_clip
);

  localparam int CW   = $clog2(MAX_SEG_POINTS + 2);
  localparam int DW   = $clog2(2 * MAX_SEG_POINTS + 3);
  localparam int ACCW = SPACE_W + CW;
  localparam int SUMW = 2 * COORD_W + 2;
  localparam int ROOTW = SUMW / 2;
  localparam int REMW = ROOTW + 2;
  localparam int QW   = COORD_W + 1;
  localparam int BCW  = $clog2(QW + 1);
  localparam logic [CW-1:0] KMAX = CW'(MAX_SEG_POINTS + 1);
  localparam logic [CW-1:0] GMAX = CW'(MAX_SEG_POINTS);
  localparam logic [BCW-1:0] SQRT_STEPS = BCW'(ROOTW);
  localparam logic [BCW-1:0] DIV_STEPS = BCW'(QW);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SQ   = 6'b000010,
    S_SQRT = 6'b000100,
    S_CNT  = 6'b001000,
    S_DIV  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    PH_PADF = 3'b001,
    PH_SAMP = 3'b010,
    PH_PADE = 3'b100
  } phase_t;

  state_t st;
  phase_t ph;

  logic signed [COORD_W-1:0] prev [AXIS_N];
  logic signed [COORD_W-1:0] start [AXIS_N];
  logic [COORD_W-1:0] mag [AXIS_N];
  logic neg [AXIS_N];
  logic have_prev;
  logic first_seg;
  logic seg_end;

  logic [1:0] axis;
  logic [2*COORD_W-1:0] sq;
  logic [SUMW-1:0] sum;
  logic [SUMW-1:0] rad;
  logic [REMW-1:0] srem;
  logic [ROOTW-1:0] root;
  logic [BCW-1:0] bits;
  logic [ACCW-1:0] acc;
  logic [CW-1:0] k;
  logic [CW-1:0] g;
  logic clip;
  logic [CW-1:0] jmax;
  logic [DW-1:0] dvs;
  logic [QW-1:0] dvd;
  logic [DW-1:0] drem;
  logic [QW-1:0] dq;
  logic [QW-1:0] qstep [AXIS_N];
  logic [DW-1:0] rstep [AXIS_N];
  logic [QW-1:0] qacc [AXIS_N];
  logic [DW-1:0] racc [AXIS_N];
  logic [CW-1:0] j;
  logic [PAD_W-1:0] padc;

  logic [REMW-1:0] s_shift;
  logic [REMW-1:0] s_trial;
  logic [DW:0] d_shift;
  logic can_out;
  logic emit_last;
  logic signed [COORD_W-1:0] samp [AXIS_N];
  logic [CW-1:0] g_fix;
  logic clip_fix;

  assign can_out = !out_valid || out_ready;
  assign q_pop = (st == S_IDLE) && q_valid;

  assign s_shift = {srem[REMW-3:0], rad[SUMW-1:SUMW-2]};
  assign s_trial = {root, 2'b01};
  assign d_shift = {drem, dvd[QW-1]};

  always_comb begin
    for (int a = 0; a < AXIS_N; a++) begin
      samp[a] = neg[a] ? start[a] - $signed(qacc[a][COORD_W-1:0])
                       : start[a] + $signed(qacc[a][COORD_W-1:0]);
    end
  end

  always_comb begin
    g_fix = g;
    clip_fix = 1'b0;
    if (g > GMAX) begin
      g_fix = GMAX;
      clip_fix = 1'b1;
    end else if (g == '0) begin
      g_fix = CW'(1);
    end
  end

  always_comb begin
    emit_last = 1'b0;
    case (ph)
      PH_PADE: emit_last = (padc == cfg.pad - 1'b1);
      PH_SAMP: emit_last = (j == jmax) && !(seg_end && cfg.pad != '0);
      default: emit_last = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      ph <= PH_PADF;
      have_prev <= 1'b0;
      first_seg <= 1'b1;
      out_valid <= 1'b0;
      for (int a = 0; a < AXIS_N; a++) begin
        prev[a] <= '0;
      end
    end else begin
      // in S_EMIT the output register is reloaded whenever it can take a point
      if (out_valid && out_ready && st != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (q_valid) begin
            seg_end <= q_item.path_end;
            if (!have_prev) begin
              prev[0] <= q_item.x;
              prev[1] <= q_item.y;
              prev[2] <= q_item.z;
              have_prev <= !q_item.path_end;
              first_seg <= 1'b1;
            end else begin
              for (int a = 0; a < AXIS_N; a++) begin
                logic signed [COORD_W:0] d;
                logic signed [COORD_W-1:0] e;
                e = (a == 0) ? q_item.x : (a == 1) ? q_item.y : q_item.z;
                d = {e[COORD_W-1], e} - {prev[a][COORD_W-1], prev[a]};
                neg[a] <= d[COORD_W];
                mag[a] <= d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
                start[a] <= prev[a];
                if (q_item.path_end) begin
                  prev[a] <= '0;
                end else begin
                  prev[a] <= e;
                end
              end
              axis <= '0;
              sum <= '0;
              st <= S_SQ;
            end
          end
        end
        S_SQ: begin
          // square is registered and added to the sum in the next cycle
          if (axis != 2'd0) begin
            sum <= sum + SUMW'(sq);
          end
          if (axis != 2'd3) begin
            sq <= mag[axis] * mag[axis];
            axis <= axis + 1'b1;
          end else begin
            rad <= sum + SUMW'(sq);
            srem <= '0;
            root <= '0;
            bits <= '0;
            st <= S_SQRT;
          end
        end
        S_SQRT: begin
          rad <= {rad[SUMW-3:0], 2'b00};
          if (s_shift >= s_trial) begin
            srem <= s_shift - s_trial;
            root <= {root[ROOTW-2:0], 1'b1};
          end else begin
            srem <= s_shift;
            root <= {root[ROOTW-2:0], 1'b0};
          end
          bits <= bits + 1'b1;
          if (bits == SQRT_STEPS - 1'b1) begin
            acc <= ACCW'(cfg.spacing);
            k <= CW'(1);
            g <= '0;
            st <= S_CNT;
          end
        end
        S_CNT: begin
          // (k*sp)^2 <= S  iff  k*sp <= isqrt(S)
          if (acc <= ACCW'(root)) begin
            g <= k;
            if (k == KMAX) begin
              st <= S_DIV;
            end else begin
              k <= k + 1'b1;
              acc <= acc + ACCW'(cfg.spacing);
            end
          end else begin
            st <= S_DIV;
          end
          if (st == S_CNT && (acc > ACCW'(root) || k == KMAX)) begin
            axis <= '0;
            bits <= '0;
            drem <= '0;
            dq <= '0;
          end
        end
        S_DIV: begin
          if (bits == '0) begin
            logic [CW-1:0] dv;
            dv = (seg_end && first_seg) ? g_fix + 1'b1 : g_fix;
            clip <= clip_fix;
            jmax <= seg_end ? g_fix : g_fix - 1'b1;
            dvs <= {dv, 1'b0} ;
            dvd <= {mag[axis], 1'b0};
            drem <= '0;
            bits <= bits + 1'b1;
          end else begin
            dvd <= {dvd[QW-2:0], 1'b0};
            if (d_shift >= {1'b0, dvs}) begin
              drem <= DW'(d_shift - {1'b0, dvs});
              dq <= {dq[QW-2:0], 1'b1};
            end else begin
              drem <= d_shift[DW-1:0];
              dq <= {dq[QW-2:0], 1'b0};
            end
            if (bits == DIV_STEPS) begin
              bits <= '0;
              if (d_shift >= {1'b0, dvs}) begin
                qstep[axis] <= {dq[QW-2:0], 1'b1};
                rstep[axis] <= DW'(d_shift - {1'b0, dvs});
              end else begin
                qstep[axis] <= {dq[QW-2:0], 1'b0};
                rstep[axis] <= d_shift[DW-1:0];
              end
              if (axis == 2'd2) begin
                for (int a = 0; a < AXIS_N; a++) begin
                  qacc[a] <= '0;
                  racc[a] <= dvs >> 1;
                end
                j <= '0;
                padc <= '0;
                if (first_seg && cfg.pad != '0) begin
                  ph <= PH_PADF;
                end else begin
                  ph <= PH_SAMP;
                end
                st <= S_EMIT;
              end else begin
                axis <= axis + 1'b1;
              end
            end else begin
              bits <= bits + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (can_out) begin
            out_valid <= 1'b1;
            out_last <= emit_last;
            out_clip <= clip;
            unique case (ph)
              PH_PADF: begin
                out_x <= start[0];
                out_y <= start[1];
                out_z <= start[2];
                if (padc == cfg.pad - 1'b1) begin
                  padc <= '0;
                  ph <= PH_SAMP;
                end else begin
                  padc <= padc + 1'b1;
                end
              end
              PH_SAMP: begin
                out_x <= samp[0];
                out_y <= samp[1];
                out_z <= samp[2];
                if (j != jmax) begin
                  j <= j + 1'b1;
                  for (int a = 0; a < AXIS_N; a++) begin
                    logic [DW:0] rs;
                    rs = {1'b0, racc[a]} + {1'b0, rstep[a]};
                    if (rs >= {1'b0, dvs}) begin
                      qacc[a] <= qacc[a] + qstep[a] + 1'b1;
                      racc[a] <= DW'(rs - {1'b0, dvs});
                    end else begin
                      qacc[a] <= qacc[a] + qstep[a];
                      racc[a] <= rs[DW-1:0];
                    end
                  end
                end else if (seg_end && cfg.pad != '0) begin
                  ph <= PH_PADE;
                end
              end
              PH_PADE: begin
                out_x <= samp[0];
                out_y <= samp[1];
                out_z <= samp[2];
                padc <= padc + 1'b1;
              end
              default: ;
            endcase
            if (emit_last) begin
              st <= S_IDLE;
              if (seg_end) begin
                have_prev <= 1'b0;
                first_seg <= 1'b1;
              end else begin
                first_seg <= 1'b0;
              end
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  a_emit_only_in_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(st) == S_EMIT)
    else $error("result loaded outside emit state");

  a_sample_index: assert property (@(posedge clk) disable iff (rst)
    (st == S_EMIT && ph == PH_SAMP) |-> j <= jmax)
    else $error("sample index beyond segment count");

  a_remainder_bound: assert property (@(posedge clk) disable iff (rst)
    (st == S_EMIT) |-> (racc[0] < dvs && racc[1] < dvs && racc[2] < dvs))
    else $error("interpolation remainder out of range");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (st == S_EMIT) |-> (jmax <= GMAX))
    else $error("segment count out of range");

endmodule
`default_nettype wire
